[rtl/tsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types, codes and constants of the tone stream converter.
// ----------------------------------------------------------------------------
package tsc_pkg;

	localparam int unsigned BYTE_W       = 8;
	localparam int unsigned REG_W        = 16;
	localparam int unsigned REG_IDX_W    = 2;
	localparam int unsigned DRIFT_W      = 32;
	localparam int unsigned FRAMES_W     = 12;  // up to (3*65535+25)/50
	localparam int unsigned CHUNK_W      = 7;

	localparam logic [CHUNK_W-1:0] FRAME_MAX        = 7'd127;
	localparam logic [6:0]         THIRDS_PER_FRAME = 7'd50;
	localparam logic [4:0]         ROUND_BIAS       = 5'd25;
	localparam logic [7:0]         JUMP_CMD         = 8'hD0;
	localparam logic [3:0]         CMD_NOTE_ON      = 4'h9;
	localparam logic [3:0]         CMD_NOTE_OFF     = 4'h8;
	localparam logic [6:0]         NOTE_MIN         = 7'd12;
	localparam logic [6:0]         NOTE_MAX         = 7'd106;
	localparam logic [REG_W-1:0]   SEG_HEADROOM     = 16'd4;

	// x / 50 == (x * RECIP_K) >> RECIP_SHIFT, exact for x < 2^24 / 34
	localparam logic [18:0]        RECIP_K          = 19'd335545;
	localparam int unsigned        RECIP_SHIFT      = 24;

	localparam logic signed [33:0] DRIFT_HI = 34'sh07FFFFFFF;
	localparam logic signed [33:0] DRIFT_LO = 34'sh380000000;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_START_ADDRESS,
		REG_SEGMENT_OFFSET,
		REG_SEGMENT_SIZE,
		REG_ADJUST_MARGIN
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_CMD,
		PH_NOTE,
		PH_DLO
	} phase_t;

	typedef enum logic [3:0] {
		SEL_HELD,
		SEL_NOTE,
		SEL_BYTE,
		SEL_CHUNK,
		SEL_JUMP,
		SEL_SEG_LO,
		SEL_SEG_HI,
		SEL_START_LO,
		SEL_START_HI
	} emit_sel_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DECODE,
		ST_NOTE_CMD,
		ST_NOTE_VAL,
		ST_CMD_BODY,
		ST_OFF_EMIT,
		ST_FL_ADD,
		ST_FL_DIV,
		ST_CH_UP,
		ST_CH_DN,
		ST_CH_EMIT,
		ST_FL_DONE,
		ST_SEG_MUL,
		ST_SEG_CMP,
		ST_JMP_CMD,
		ST_JMP_LO,
		ST_JMP_HI,
		ST_END_CMD,
		ST_END_LO,
		ST_END_HI
	} tsc_state_t;

	typedef struct packed {
		logic      load_in;
		logic      note_start;
		logic      delay_lo;
		logic      delay_hi;
		logic      hold_note;
		logic      off_count;
		logic      fl_add;
		logic      fl_frames;
		logic      fl_close;
		logic      ch_up;
		logic      ch_dn;
		logic      seg_mul;
		logic      seg_step;
		logic      emit;
		emit_sel_t sel;
	} tsc_cmd_t;

	typedef struct packed {
		phase_t phase;
		logic   bit7;
		logic   is_on;
		logic   is_off;
		logic   last;
		logic   dly_open;
		logic   flush_nz;
		logic   frames_zero;
		logic   chunk_last;
		logic   seg_hit;
		logic   out_free;
	} tsc_stat_t;

	function automatic logic signed [DRIFT_W-1:0] sat_drift(input logic signed [33:0] v);
		logic signed [DRIFT_W-1:0] r;
		if (v > DRIFT_HI) begin
			r = DRIFT_HI[DRIFT_W-1:0];
		end else if (v < DRIFT_LO) begin
			r = DRIFT_LO[DRIFT_W-1:0];
		end else begin
			r = v[DRIFT_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [12:0] times_fifty(input logic [CHUNK_W-1:0] d);
		return 13'(d) * 13'(THIRDS_PER_FRAME);
	endfunction

endpackage

[rtl/tsc_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_in_if
// Source byte channel: valid/ready with byte and end-of-stream flag.
// ----------------------------------------------------------------------------
interface tsc_in_if;
	import tsc_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;
	logic              in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

[rtl/tsc_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_out_if
// Player byte channel: valid/ready with byte and end-marker flag.
// ----------------------------------------------------------------------------
interface tsc_out_if;
	import tsc_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

[rtl/tsc_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_cfg_if
// Register write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface tsc_cfg_if;
	import tsc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [REG_IDX_W-1:0] reg_index;
	logic [REG_W-1:0]     reg_data;

	modport source (output valid, output reg_index, output reg_data, input ready);
	modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

[rtl/tone_stream_converter_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tone_stream_converter_unit
// Tone-command byte stream to compact player byte stream converter.
// ----------------------------------------------------------------------------
// Takes one source byte per transaction and produces the player byte stream,
// one byte per output transaction, with out_last on the final byte of the
// closing loop-back marker. Source bytes are taken one at a time by a
// sequencer that holds the input off while it decodes each byte and sends
// its output bytes (the byte of a note-off, the two bytes of a note). A
// segment check does one multiply and one compare, and a jump marker may
// follow it; the end marker closes the stream. Flushing a delay run does
// its setup and then one chunk loop pass per chunk, the remainder chunk
// included, so a long run holds the input off until its last chunk is out. An
// output register parts the two sides: a new byte is accepted while the
// last result still waits downstream, and emitting stalls only while that
// register is full and not being taken. Registers may be written only while
// the unit is idle; the register write channel is always ready.
// ----------------------------------------------------------------------------
module tone_stream_converter_unit (
	input  logic       clk,
	input  logic       arst_n,
	tsc_in_if.sink     src,
	tsc_out_if.source  dst,
	tsc_cfg_if.sink    cfg
);
	import tsc_pkg::*;

	tsc_cmd_t  cmd;
	tsc_stat_t st;

	// writes are registered directly, no back-pressure needed
	assign cfg.ready = 1'b1;

	// sequencer: decode, flush loop, chunk loop and marker insertion
	tsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src.valid),
		.src_ready (src.ready),
		.st        (st),
		.cmd       (cmd)
	);

	// stream state, frame arithmetic, segment bookkeeping and output register
	tsc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_byte   (src.in_byte),
		.in_last   (src.in_last),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.reg_index),
		.cfg_data  (cfg.reg_data),
		.out_ready (dst.ready),
		.out_valid (dst.valid),
		.out_byte  (dst.out_byte),
		.out_last  (dst.out_last),
		.cmd       (cmd),
		.st        (st)
	);

endmodule

[rtl/tsc_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_datapath
// Stream state, delay/frame arithmetic, segment bookkeeping, output register.
// ----------------------------------------------------------------------------
module tsc_datapath (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [7:0]               in_byte,
	input  logic                     in_last,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [15:0]              cfg_data,
	input  logic                     out_ready,
	output logic                     out_valid,
	output logic [7:0]               out_byte,
	output logic                     out_last,
	input  tsc_pkg::tsc_cmd_t        cmd,
	output tsc_pkg::tsc_stat_t       st
);
	import tsc_pkg::*;

	// registers
	logic [REG_W-1:0]          start_q, offset_q, size_q, margin_q;
	logic [BYTE_W-1:0]         byte_q, held_q, dly_high_q;
	logic                      last_q, dly_open_q;
	phase_t                    phase_q;
	logic [REG_W-1:0]          dly_sum_q, cnt_q, seg_num_q, seg_base_q;
	logic signed [DRIFT_W-1:0] drift_q;
	logic [36:0]               prod_q;
	logic [FRAMES_W-1:0]       rem_q;
	logic [CHUNK_W-1:0]        chunk_q;
	logic                      chunk_last_q;
	logic [32:0]               bound_q;
	logic                      out_valid_q, out_last_q;
	logic [BYTE_W-1:0]         out_byte_q;

	// combinational
	logic [17:0]               three_sum, dly_x;
	logic signed [33:0]        drift_x;
	logic [CHUNK_W-1:0]        d0;
	logic                      rem_full;
	logic [16:0]               up_lim;
	logic signed [33:0]        dn_lim;
	logic                      bump_up, bump_dn;
	logic [FRAMES_W-1:0]       frames;
	logic [REG_W-1:0]          span;
	logic                      seg_en;
	logic [6:0]                note_v;
	logic [BYTE_W-1:0]         emit_byte;
	logic                      clear_stream;

	assign three_sum = {2'b00, dly_sum_q} + {1'b0, dly_sum_q, 1'b0};
	assign dly_x     = three_sum + 18'(ROUND_BIAS);
	assign drift_x   = $signed({{2{drift_q[DRIFT_W-1]}}, drift_q});
	assign frames    = prod_q[RECIP_SHIFT +: FRAMES_W];

	// chunk sizing: raise first, then lower against the adjusted size
	assign rem_full = rem_q >= FRAMES_W'(FRAME_MAX);
	assign d0       = rem_full ? FRAME_MAX : rem_q[CHUNK_W-1:0];
	assign up_lim   = 17'(times_fifty(d0)) + 17'(margin_q);
	assign bump_up  = (margin_q != '0) && (drift_x > $signed({17'b0, up_lim}))
		&& (d0 < FRAME_MAX);
	assign dn_lim   = $signed({21'b0, times_fifty(chunk_q)}) - $signed({18'b0, margin_q});
	assign bump_dn  = (margin_q != '0) && (drift_x < dn_lim) && (chunk_q > 7'd1);

	assign span   = size_q - SEG_HEADROOM;
	assign seg_en = (size_q > SEG_HEADROOM) && (offset_q != '0);

	always_comb begin
		note_v = byte_q[6:0];
		if (note_v < NOTE_MIN) begin
			note_v = NOTE_MIN;
		end else if (note_v > NOTE_MAX) begin
			note_v = NOTE_MAX;
		end
	end

	always_comb begin
		case (cmd.sel)
			SEL_HELD:     emit_byte = held_q;
			SEL_NOTE:     emit_byte = {1'b0, note_v};
			SEL_BYTE:     emit_byte = byte_q;
			SEL_CHUNK:    emit_byte = {1'b0, chunk_q};
			SEL_JUMP:     emit_byte = JUMP_CMD;
			SEL_SEG_LO:   emit_byte = seg_base_q[7:0];
			SEL_SEG_HI:   emit_byte = seg_base_q[15:8];
			SEL_START_LO: emit_byte = start_q[7:0];
			SEL_START_HI: emit_byte = start_q[15:8];
			default:      emit_byte = JUMP_CMD;
		endcase
	end

	assign clear_stream = cmd.emit && (cmd.sel == SEL_START_HI);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= '0;
			offset_q <= '0;
			size_q   <= '0;
			margin_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_START_ADDRESS:  start_q  <= cfg_data;
				REG_SEGMENT_OFFSET: offset_q <= cfg_data;
				REG_SEGMENT_SIZE:   size_q   <= cfg_data;
				REG_ADJUST_MARGIN:  margin_q <= cfg_data;
			endcase
		end
	end

	// parser and stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_CMD;
			held_q     <= '0;
			dly_high_q <= '0;
			dly_sum_q  <= '0;
			dly_open_q <= 1'b0;
			cnt_q      <= '0;
			seg_num_q  <= '0;
			seg_base_q <= '0;
			drift_q    <= '0;
		end else if (clear_stream) begin
			phase_q    <= PH_CMD;
			held_q     <= '0;
			dly_high_q <= '0;
			dly_sum_q  <= '0;
			dly_open_q <= 1'b0;
			cnt_q      <= '0;
			seg_num_q  <= '0;
			seg_base_q <= start_q;
			drift_q    <= '0;
		end else begin
			if (cmd.note_start) begin
				phase_q <= PH_CMD;
				cnt_q   <= cnt_q + 16'd2;
			end
			if (cmd.delay_lo) begin
				phase_q   <= PH_CMD;
				dly_sum_q <= dly_sum_q + {dly_high_q, byte_q};
			end
			if (cmd.delay_hi) begin
				phase_q    <= PH_DLO;
				dly_high_q <= byte_q;
				dly_open_q <= 1'b1;
				if (!dly_open_q) begin
					dly_sum_q <= '0;
				end
			end
			if (cmd.hold_note) begin
				phase_q <= PH_NOTE;
				held_q  <= byte_q;
			end
			if (cmd.off_count) begin
				cnt_q <= cnt_q + 16'd1;
			end
			if (cmd.fl_add) begin
				drift_q <= sat_drift(drift_x + $signed({16'b0, three_sum}));
			end
			if (cmd.fl_close) begin
				dly_open_q <= 1'b0;
				dly_sum_q  <= '0;
			end
			if (cmd.emit && (cmd.sel == SEL_CHUNK)) begin
				drift_q <= sat_drift(drift_x - $signed({21'b0, times_fifty(chunk_q)}));
				cnt_q   <= cnt_q + 16'd1;
			end
			if (cmd.seg_step) begin
				cnt_q      <= cnt_q + 16'd3;
				seg_num_q  <= seg_num_q + 16'd1;
				seg_base_q <= seg_base_q + offset_q;
			end
			if (cfg_we && (reg_idx_t'(cfg_index) == REG_START_ADDRESS)
				&& (seg_num_q == '0)) begin
				seg_base_q <= cfg_data;
			end
		end
	end

	// arithmetic working registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			byte_q <= in_byte;
			last_q <= in_last;
		end
		if (cmd.fl_add) begin
			prod_q <= 37'(dly_x) * 37'(RECIP_K);
		end
		if (cmd.fl_frames) begin
			rem_q <= frames;
		end
		if (cmd.ch_up) begin
			chunk_q      <= d0 + CHUNK_W'(bump_up);
			chunk_last_q <= !rem_full;
			if (rem_full) begin
				rem_q <= rem_q - FRAMES_W'(FRAME_MAX);
			end
		end
		if (cmd.ch_dn && bump_dn) begin
			chunk_q <= chunk_q - 7'd1;
		end
		if (cmd.seg_mul) begin
			bound_q <= (17'(seg_num_q) + 17'd1) * 33'(span);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_byte_q <= emit_byte;
			out_last_q <= (cmd.sel == SEL_START_HI);
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

	always_comb begin
		st.phase       = phase_q;
		st.bit7        = byte_q[7];
		st.is_on       = byte_q[7:4] == CMD_NOTE_ON;
		st.is_off      = byte_q[7:4] == CMD_NOTE_OFF;
		st.last        = last_q;
		st.dly_open    = dly_open_q;
		st.flush_nz    = dly_open_q && (dly_sum_q != '0);
		st.frames_zero = frames == '0;
		st.chunk_last  = chunk_last_q;
		st.seg_hit     = seg_en && ({17'b0, cnt_q} >= bound_q);
		st.out_free    = !out_valid_q || out_ready;
	end

endmodule

[rtl/tsc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_ctrl
// Sequencer: byte decode, delay flush, chunk loop, segment and end markers.
// ----------------------------------------------------------------------------
module tsc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_ready,
	input  tsc_pkg::tsc_stat_t  st,
	output tsc_pkg::tsc_cmd_t   cmd
);
	import tsc_pkg::*;

	tsc_state_t state_q, state_d;
	logic       cont_q, cont_d;   // after flush: segment check, then command body

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cont_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cont_q  <= cont_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		cont_d  = cont_q;
		unique case (state_q)
			ST_IDLE: begin
				if (src_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cont_d = (st.phase == PH_CMD) && st.bit7 && st.dly_open;
				if (st.phase == PH_NOTE) begin
					state_d = ST_NOTE_CMD;
				end else if (st.phase == PH_DLO) begin
					state_d = st.last ? ST_FL_ADD : ST_IDLE;
				end else if (!st.bit7) begin
					state_d = st.last ? ST_FL_ADD : ST_IDLE;
				end else begin
					state_d = st.dly_open ? ST_FL_ADD : ST_CMD_BODY;
				end
			end
			ST_NOTE_CMD: begin
				if (st.out_free) begin
					state_d = ST_NOTE_VAL;
				end
			end
			ST_NOTE_VAL: begin
				if (st.out_free) begin
					state_d = st.last ? ST_END_CMD : ST_SEG_MUL;
				end
			end
			ST_CMD_BODY: begin
				cont_d = 1'b0;
				if (st.is_on) begin
					state_d = st.last ? ST_END_CMD : ST_IDLE;
				end else if (st.is_off) begin
					state_d = ST_OFF_EMIT;
				end else begin
					state_d = st.last ? ST_END_CMD : ST_SEG_MUL;
				end
			end
			ST_OFF_EMIT: begin
				if (st.out_free) begin
					state_d = st.last ? ST_END_CMD : ST_SEG_MUL;
				end
			end
			ST_FL_ADD: begin
				state_d = st.flush_nz ? ST_FL_DIV : ST_FL_DONE;
			end
			ST_FL_DIV: begin
				state_d = st.frames_zero ? ST_FL_DONE : ST_CH_UP;
			end
			ST_CH_UP: begin
				state_d = ST_CH_DN;
			end
			ST_CH_DN: begin
				state_d = ST_CH_EMIT;
			end
			ST_CH_EMIT: begin
				if (st.out_free) begin
					state_d = st.chunk_last ? ST_FL_DONE : ST_CH_UP;
				end
			end
			ST_FL_DONE: begin
				state_d = cont_q ? ST_SEG_MUL : ST_END_CMD;
			end
			ST_SEG_MUL: begin
				state_d = ST_SEG_CMP;
			end
			ST_SEG_CMP: begin
				if (st.seg_hit) begin
					state_d = ST_JMP_CMD;
				end else begin
					state_d = cont_q ? ST_CMD_BODY : ST_IDLE;
				end
			end
			ST_JMP_CMD: begin
				if (st.out_free) begin
					state_d = ST_JMP_LO;
				end
			end
			ST_JMP_LO: begin
				if (st.out_free) begin
					state_d = ST_JMP_HI;
				end
			end
			ST_JMP_HI: begin
				if (st.out_free) begin
					state_d = cont_q ? ST_CMD_BODY : ST_IDLE;
				end
			end
			ST_END_CMD: begin
				if (st.out_free) begin
					state_d = ST_END_LO;
				end
			end
			ST_END_LO: begin
				if (st.out_free) begin
					state_d = ST_END_HI;
				end
			end
			ST_END_HI: begin
				if (st.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd       = '0;
		cmd.sel   = SEL_HELD;
		src_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				src_ready   = 1'b1;
				cmd.load_in = src_valid;
			end
			ST_DECODE: begin
				if (st.phase == PH_NOTE) begin
					cmd.note_start = 1'b1;
				end else if (st.phase == PH_DLO) begin
					cmd.delay_lo = 1'b1;
				end else if (!st.bit7 && !st.last) begin
					cmd.delay_hi = 1'b1;
				end
			end
			ST_NOTE_CMD: begin
				cmd.emit = st.out_free;
				cmd.sel  = SEL_HELD;
			end
			ST_NOTE_VAL: begin
				cmd.emit = st.out_free;
				cmd.sel  = SEL_NOTE;
			end
			ST_CMD_BODY: begin
				cmd.hold_note = st.is_on && !st.last;
				cmd.off_count = st.is_off;
			end
			ST_OFF_EMIT: begin
				cmd.emit = st.out_free;
				cmd.sel  = SEL_BYTE;
			end
			ST_FL_ADD: begin
				cmd.fl_add = st.flush_nz;
			end
			ST_FL_DIV: begin
				cmd.fl_frames = 1'b1;
			end
			ST_CH_UP: begin
				cmd.ch_up = 1'b1;
			end
			ST_CH_DN: begin
				cmd.ch_dn = 1'b1;
			end
			ST_CH_EMIT: begin
				cmd.emit = st.out_free;
				cmd.sel  = SEL_CHUNK;
			end
			ST_FL_DONE: begin
				cmd.fl_close = 1'b1;
			end
			ST_SEG_MUL: begin
				cmd.seg_mul = 1'b1;
			end
			ST_SEG_CMP: begin
				cmd.seg_step = st.seg_hit;
			end
			ST_JMP_CMD: begin
				cmd.emit = st.out_free;
				cmd.sel  = SEL_JUMP;
			end
			ST_JMP_LO: begin
				cmd.emit = st.out_free;
				cmd.sel  = SEL_SEG_LO;
			end
			ST_JMP_HI: begin
				cmd.emit = st.out_free;
				cmd.sel  = SEL_SEG_HI;
			end
			ST_END_CMD: begin
				cmd.emit = st.out_free;
				cmd.sel  = SEL_JUMP;
			end
			ST_END_LO: begin
				cmd.emit = st.out_free;
				cmd.sel  = SEL_START_LO;
			end
			ST_END_HI: begin
				cmd.emit = st.out_free;
				cmd.sel  = SEL_START_HI;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

[tb/tone_stream_converter_unit_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tone_stream_converter_unit_checker
// Follows register writes and source transactions, predicts the player byte
// stream and compares every output transaction against it, in order.
// ----------------------------------------------------------------------------
module tone_stream_converter_unit_checker (
	input  logic clk,
	input  logic arst_n,
	tsc_in_if    src,
	tsc_out_if   dst,
	tsc_cfg_if   cfg,
	output int   mismatches,
	output int   bytes_due
);
	import tsc_pkg::*;

	localparam longint        CHUNK_TOP    = longint'(FRAME_MAX);
	localparam longint        FRAME_THIRDS = longint'(THIRDS_PER_FRAME);
	localparam longint        DRIFT_TOP    = 64'sd2147483647;
	localparam longint        DRIFT_BOTTOM = -64'sd2147483648;
	localparam logic [7:0]    NOTE_FOLD    = 8'd128;

	typedef struct packed {
		logic [BYTE_W-1:0] b;
		logic              l;
	} player_byte_t;

	player_byte_t player_bytes_due[$];

	// register copies
	logic [REG_W-1:0] r_start, r_offset, r_size, r_margin;

	// converter state
	phase_t             ph;
	logic [7:0]         held_cmd;
	logic [7:0]         dly_hi;
	logic [15:0]        dly_sum;
	logic               dly_open;
	logic [15:0]        byte_tally;
	logic [15:0]        seg_idx;
	logic [15:0]        seg_base;
	logic signed [31:0] drift;

	task automatic report_fault(input string msg);
		$display("[%0t] %s", $time, msg);
		mismatches++;
	endtask

	task automatic put_byte(input logic [7:0] b, input logic l);
		player_bytes_due.push_back({b, l});
	endtask

	task automatic restart_stream();
		ph         = PH_CMD;
		held_cmd   = '0;
		dly_hi     = '0;
		dly_sum    = '0;
		dly_open   = 1'b0;
		byte_tally = '0;
		seg_idx    = '0;
		seg_base   = r_start;
		drift      = '0;
	endtask

	function automatic logic signed [31:0] clamp_drift(input longint v);
		if (v > DRIFT_TOP)
			return DRIFT_TOP[31:0];
		if (v < DRIFT_BOTTOM)
			return DRIFT_BOTTOM[31:0];
		return v[31:0];
	endfunction

	// one chunk of frames, nudged one frame toward the drift when enabled
	task automatic send_frames(input longint d);
		longint m;
		m = longint'(r_margin);
		if (r_margin != '0) begin
			if (longint'(drift) > d * FRAME_THIRDS + m && d < CHUNK_TOP)
				d++;
			if (longint'(drift) < d * FRAME_THIRDS - m && d > 1)
				d--;
		end
		drift = clamp_drift(longint'(drift) - d * FRAME_THIRDS);
		put_byte(8'(d), 1'b0);
	endtask

	task automatic flush_run();
		int unsigned frames;
		int unsigned full;
		if (dly_open && dly_sum != '0) begin
			drift  = clamp_drift(longint'(drift) + 3 * longint'(dly_sum));
			frames = (32'(dly_sum) * 3 + 32'(ROUND_BIAS)) / 32'(THIRDS_PER_FRAME);
			if (frames != 0) begin
				full       = frames / 32'(FRAME_MAX);
				byte_tally = byte_tally + 16'(full + 1);
				repeat (full) send_frames(CHUNK_TOP);
				send_frames(longint'(frames % 32'(FRAME_MAX)));
			end
		end
		dly_open = 1'b0;
		dly_sum  = '0;
	endtask

	task automatic check_segment();
		int unsigned span;
		if (r_size <= SEG_HEADROOM || r_offset == '0)
			return;
		span = 32'(r_size) - 32'(SEG_HEADROOM);
		if (32'(byte_tally) / span > 32'(seg_idx)) begin
			byte_tally = byte_tally + 16'd3;
			seg_idx    = seg_idx + 16'd1;
			seg_base   = seg_base + r_offset;
			put_byte(JUMP_CMD, 1'b0);
			put_byte(seg_base[7:0], 1'b0);
			put_byte(seg_base[15:8], 1'b0);
		end
	endtask

	task automatic close_stream();
		put_byte(JUMP_CMD, 1'b0);
		put_byte(r_start[7:0], 1'b0);
		put_byte(r_start[15:8], 1'b1);
		restart_stream();
	endtask

	task automatic finish_item(input logic last);
		if (last)
			close_stream();
		else
			check_segment();
	endtask

	task automatic convert_byte(input logic [7:0] b, input logic last);
		logic [7:0] note;
		case (ph)
		PH_NOTE: begin
			note = b;
			if (note >= NOTE_FOLD)
				note = note - NOTE_FOLD;
			if (note < NOTE_MIN)
				note = 8'(NOTE_MIN);
			if (note > NOTE_MAX)
				note = 8'(NOTE_MAX);
			ph         = PH_CMD;
			byte_tally = byte_tally + 16'd2;
			put_byte(held_cmd, 1'b0);
			put_byte(note, 1'b0);
			finish_item(last);
		end
		PH_DLO: begin
			dly_sum = dly_sum + {dly_hi, b};
			ph      = PH_CMD;
			if (last) begin
				flush_run();
				close_stream();
			end
		end
		default: begin
			ph = PH_CMD;
			if (!b[7]) begin
				if (last) begin
					// dangling delay byte: pending run still goes out
					flush_run();
					close_stream();
				end else begin
					if (!dly_open) begin
						dly_open = 1'b1;
						dly_sum  = '0;
					end
					dly_hi = b;
					ph     = PH_DLO;
				end
			end else begin
				if (dly_open) begin
					flush_run();
					check_segment();
				end
				if (b[7:4] == CMD_NOTE_ON) begin
					if (last) begin
						close_stream();
					end else begin
						held_cmd = b;
						ph       = PH_NOTE;
					end
				end else if (b[7:4] == CMD_NOTE_OFF) begin
					byte_tally = byte_tally + 16'd1;
					put_byte(b, 1'b0);
					finish_item(last);
				end else begin
					finish_item(last);
				end
			end
		end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		player_byte_t due;
		if (!arst_n) begin
			r_start  = '0;
			r_offset = '0;
			r_size   = '0;
			r_margin = '0;
			restart_stream();
			player_bytes_due.delete();
			mismatches = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (reg_idx_t'(cfg.reg_index))
				REG_START_ADDRESS: begin
					r_start = cfg.reg_data;
					if (seg_idx == '0)
						seg_base = cfg.reg_data;
				end
				REG_SEGMENT_OFFSET: r_offset = cfg.reg_data;
				REG_SEGMENT_SIZE:   r_size   = cfg.reg_data;
				REG_ADJUST_MARGIN:  r_margin = cfg.reg_data;
				endcase
			end
			if (dst.valid && dst.ready) begin
				if (player_bytes_due.size() == 0) begin
					report_fault($sformatf("unexpected player byte 0x%02h last %0b",
						dst.out_byte, dst.out_last));
				end else begin
					due = player_bytes_due.pop_front();
					if (dst.out_byte !== due.b)
						report_fault($sformatf("out_byte 0x%02h, expected 0x%02h",
							dst.out_byte, due.b));
					if (dst.out_last !== due.l)
						report_fault($sformatf("out_last %0b, expected %0b (byte 0x%02h)",
							dst.out_last, due.l, due.b));
				end
			end
			if (src.valid && src.ready)
				convert_byte(src.in_byte, src.in_last);
		end
		bytes_due = player_bytes_due.size();
	end

endmodule

[tb/tone_stream_converter_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tone_stream_converter_unit_tb
// Drives source byte streams and register settings into the converter; the
// checker beside it predicts and compares the player stream.
// ----------------------------------------------------------------------------
// A directed stream first (note clamping and folding, note-off, dropped
// commands, zero and wrapping delay runs, long runs split into chunks, a
// dangling note-on and a dangling delay byte), then random streams under six
// register settings, extremes among them. Idling: sender 22 % / receiver 63 %
// for two settings, the reverse for two, none for the last two.
// ----------------------------------------------------------------------------
module tone_stream_converter_unit_tb;
	import tsc_pkg::*;

	localparam int STALL_LIMIT              = 2000;
	localparam int SETTLE_CYCLES            = 40;
	localparam int RANDOM_BYTES_PER_SETTING = 50;

	typedef struct {
		logic [REG_W-1:0] base_addr;
		logic [REG_W-1:0] step;
		logic [REG_W-1:0] seg_bytes;
		logic [REG_W-1:0] margin;
	} reg_set_t;

	typedef enum {
		IT_NOTE_ON,
		IT_NOTE_OFF,
		IT_OTHER_CMD,
		IT_DELAY,
		IT_NOISE
	} item_kind_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	tsc_in_if  src ();
	tsc_out_if dst ();
	tsc_cfg_if cfg ();

	int mismatches;
	int bytes_due;
	int src_gap_pct;
	int sink_gap_pct;
	int stall_cycles;
	int sent_bytes;

	// notes around the fold and clamp points
	logic [7:0] note_edges [9] = '{8'd0, 8'd11, 8'd12, 8'd106, 8'd107,
		8'd127, 8'd128, 8'd140, 8'd255};

	// note-ons with folding/clamping, note-offs, dropped commands, a zero run,
	// a run that wraps to 1 ms (no frames), a one-frame run, dangling note-on
	logic [7:0] directed_main [] = '{
		8'h90, 8'h00, 8'h9F, 8'hFF, 8'h95, 8'h80, 8'h91, 8'h3C,
		8'h80, 8'h8F, 8'hA5, 8'h00, 8'h00, 8'hF0,
		8'h7F, 8'hFF, 8'h7F, 8'hFF, 8'h00, 8'h03, 8'h80,
		8'h00, 8'h09, 8'h9A};
	// long pending run, many chunks, closed by a dangling delay byte
	logic [7:0] directed_tail [] = '{8'h7F, 8'h00, 8'h05};

	// extremes among them; entry three is filled at random
	reg_set_t settings [6] = '{
		'{16'h1234, 16'h0100, 16'd20,    16'd50},
		'{16'hFFFF, 16'hFFFF, 16'd5,     16'hFFFF},
		'{16'h0000, 16'h0001, 16'hFFFF,  16'd1},
		'{16'h0000, 16'h0000, 16'd0,     16'd0},
		'{16'hABCD, 16'h0040, 16'd4,     16'd0},
		'{16'h5A5A, 16'h0000, 16'd12,    16'd300}};

	always #6 clk = ~clk;

	tone_stream_converter_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src),
		.dst    (dst),
		.cfg    (cfg)
	);

	tone_stream_converter_unit_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.src        (src),
		.dst        (dst),
		.cfg        (cfg),
		.mismatches (mismatches),
		.bytes_due  (bytes_due)
	);

	// receiver back-pressure, redrawn every cycle
	always @(negedge clk) begin
		dst.ready = ($urandom_range(99) >= sink_gap_pct);
	end

	// watchdog: cycles with no transaction on any channel
	always @(posedge clk) begin
		if ((src.valid && src.ready) || (dst.valid && dst.ready) || (cfg.valid && cfg.ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// One source transaction. Called at a falling edge; returns at the falling
	// edge after acceptance with valid still high, so back-to-back bytes do not
	// drop valid in between.
	task automatic push_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < src_gap_pct) begin
			src.valid = 1'b0;
			@(negedge clk);
		end
		src.valid   = 1'b1;
		src.in_byte = b;
		src.in_last = last;
		do
			@(posedge clk);
		while (src.ready !== 1'b1);
		@(negedge clk);
		sent_bytes++;
	endtask

	// sender holds off until every predicted byte has come out
	task automatic wait_drained(input int extra);
		src.valid = 1'b0;
		while (bytes_due != 0)
			@(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	// registers only change once the unit has gone quiet
	task automatic apply_settings(input reg_set_t s);
		wait_drained(SETTLE_CYCLES);
		write_reg(REG_START_ADDRESS, s.base_addr);
		write_reg(REG_SEGMENT_OFFSET, s.step);
		write_reg(REG_SEGMENT_SIZE, s.seg_bytes);
		write_reg(REG_ADJUST_MARGIN, s.margin);
		cfg.valid = 1'b0;
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [REG_W-1:0] v);
		cfg.valid     = 1'b1;
		cfg.reg_index = idx;
		cfg.reg_data  = v;
		do
			@(posedge clk);
		while (cfg.ready !== 1'b1);
		@(negedge clk);
	endtask

	function automatic item_kind_t pick_kind();
		int roll;
		roll = $urandom_range(99);
		if (roll < 30)
			return IT_NOTE_ON;
		if (roll < 50)
			return IT_NOTE_OFF;
		if (roll < 60)
			return IT_OTHER_CMD;
		if (roll < 95)
			return IT_DELAY;
		return IT_NOISE;
	endfunction

	// one well-formed item (noise aside); last flags its final byte
	task automatic send_item(input item_kind_t kind, input logic last);
		logic [7:0] note;
		logic [7:0] dly_hi;
		case (kind)
		IT_NOTE_ON: begin
			if ($urandom_range(3) == 0)
				note = note_edges[$urandom_range(8)];
			else
				note = 8'($urandom);
			push_byte({CMD_NOTE_ON, 4'($urandom)}, 1'b0);
			push_byte(note, last);
		end
		IT_NOTE_OFF: push_byte({CMD_NOTE_OFF, 4'($urandom)}, last);
		IT_OTHER_CMD: push_byte(8'($urandom_range(8'hA0, 8'hFF)), last);
		IT_DELAY: begin
			// mostly short delays, now and then a long one that splits into chunks
			if ($urandom_range(9) == 0)
				dly_hi = 8'($urandom_range(127));
			else
				dly_hi = 8'($urandom_range(2));
			push_byte(dly_hi, 1'b0);
			push_byte(8'($urandom), last);
		end
		default: push_byte(8'($urandom), last);
		endcase
	endtask

	task automatic run_stream(input int n_items);
		repeat (n_items - 1) begin
			if ($urandom_range(99) < 3)
				wait_drained(0);
			send_item(pick_kind(), 1'b0);
		end
		case ($urandom_range(5))
		0: push_byte({CMD_NOTE_ON, 4'($urandom)}, 1'b1);  // dangling note-on
		1: push_byte(8'($urandom_range(127)), 1'b1);      // dangling delay byte
		default: send_item(pick_kind(), 1'b1);
		endcase
	endtask

	initial begin
		int target;
		src.valid     = 1'b0;
		src.in_byte   = '0;
		src.in_last   = 1'b0;
		cfg.valid     = 1'b0;
		cfg.reg_index = '0;
		cfg.reg_data  = '0;

		settings[3] = '{16'($urandom), 16'($urandom), 16'($urandom_range(5, 64)),
			16'($urandom_range(1, 400))};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (settings[p]) begin
			if (p < 2) begin
				src_gap_pct  = 22;
				sink_gap_pct = 63;
			end else if (p < 4) begin
				src_gap_pct  = 63;
				sink_gap_pct = 22;
			end else begin
				src_gap_pct  = 0;
				sink_gap_pct = 0;
			end
			apply_settings(settings[p]);

			if (p == 0) begin
				foreach (directed_main[i]) begin
					// hold off once with the whole stream drained
					if (i == directed_main.size() - 1)
						wait_drained(0);
					push_byte(directed_main[i], i == directed_main.size() - 1);
				end
				foreach (directed_tail[i])
					push_byte(directed_tail[i], i == directed_tail.size() - 1);
			end

			target = sent_bytes + RANDOM_BYTES_PER_SETTING;
			while (sent_bytes < target)
				run_stream($urandom_range(4, 25));
		end

		wait_drained(SETTLE_CYCLES);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
